>>> hw/rtl/i2cms_pkg.sv
// Package with the shared types, opcodes and register indexes of the I2C bit sequencer.
`timescale 1ns / 1ps

package i2cms_pkg;

   localparam int TickWidth = 8;
   localparam int ByteWidth = 8;
   localparam int OpWidth   = 3;
   localparam int CsrIdxWidth = 2;

   localparam logic [OpWidth-1:0] OP_NONE  = 3'd0;
   localparam logic [OpWidth-1:0] OP_START = 3'd1;
   localparam logic [OpWidth-1:0] OP_STOP  = 3'd2;
   localparam logic [OpWidth-1:0] OP_SEND  = 3'd3;
   localparam logic [OpWidth-1:0] OP_WACK  = 3'd4;
   localparam logic [OpWidth-1:0] OP_READ  = 3'd5;

   localparam logic [CsrIdxWidth-1:0] CSR_START_HOLD  = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_BIT_HALF    = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_SHORT_PHASE = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_ACK_TIMEOUT = 2'd3;

   localparam logic [TickWidth-1:0] START_HOLD_RESET  = 8'd4;
   localparam logic [TickWidth-1:0] BIT_HALF_RESET    = 8'd2;
   localparam logic [TickWidth-1:0] SHORT_PHASE_RESET = 8'd1;
   localparam logic [TickWidth-1:0] ACK_TIMEOUT_RESET = 8'd250;

   typedef struct packed {
      logic [TickWidth-1:0] start_hold;
      logic [TickWidth-1:0] bit_half;
      logic [TickWidth-1:0] short_phase;
      logic [TickWidth-1:0] ack_timeout;
   } cfg_type;

   typedef struct packed {
      logic [OpWidth-1:0]   opcode;
      logic [ByteWidth-1:0] tx_byte;
      logic                 ack_after_read;
      logic                 sda_in;
   } req_type;

   typedef struct packed {
      logic                 ack_failed;
      logic [ByteWidth-1:0] rx_byte;
      logic                 done_res;
      logic                 busy_res;
      logic                 sda_oe;
      logic                 sda_out;
      logic                 scl;
   } rsp_type;

endpackage

>>> hw/rtl/i2cms_csr.sv
// Timing configuration registers of the I2C bit sequencer.
`timescale 1ns / 1ps

module i2cms_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [i2cms_pkg::CsrIdxWidth-1:0]   csr_index,
   input  logic [i2cms_pkg::TickWidth-1:0]     csr_wdata,
   output i2cms_pkg::cfg_type                  cfg
);

   i2cms_pkg::cfg_type cfg_ff;
   i2cms_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            i2cms_pkg::CSR_START_HOLD:  cfg_in.start_hold  = csr_wdata;
            i2cms_pkg::CSR_BIT_HALF:    cfg_in.bit_half    = csr_wdata;
            i2cms_pkg::CSR_SHORT_PHASE: cfg_in.short_phase = csr_wdata;
            i2cms_pkg::CSR_ACK_TIMEOUT: cfg_in.ack_timeout = csr_wdata;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_hold  <= i2cms_pkg::START_HOLD_RESET;
         cfg_ff.bit_half    <= i2cms_pkg::BIT_HALF_RESET;
         cfg_ff.short_phase <= i2cms_pkg::SHORT_PHASE_RESET;
         cfg_ff.ack_timeout <= i2cms_pkg::ACK_TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hw/rtl/i2cms_core.sv
// Phase sequencer of the I2C bit sequencer: one tick of state update per transfer.
`timescale 1ns / 1ps

module i2cms_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               tick_en,
   input  i2cms_pkg::req_type req,
   input  i2cms_pkg::cfg_type cfg,
   output i2cms_pkg::rsp_type rsp
);

   typedef enum logic [3:0] {
      PH_IDLE, PH_ST1, PH_ST2, PH_SP1, PH_SP2, PH_SB_LO, PH_SB_HI,
      PH_WA1, PH_WA2, PH_WA3, PH_RB_LO, PH_RB_HI, PH_AK_LO, PH_AK_HI
   } phase_type;

   typedef struct packed {
      logic                                scl;
      logic                                sda;
      logic                                oe;
      logic [i2cms_pkg::ByteWidth-1:0]     shift;
   } pins_type;

   phase_type                         phase_ff, phase_in;
   logic [i2cms_pkg::TickWidth-1:0]   tick_ff, tick_in;
   logic [3:0]                        bitc_ff, bitc_in;
   logic [i2cms_pkg::TickWidth-1:0]   wait_ff, wait_in;
   pins_type                          pins_ff, pins_in;
   logic                              ackc_ff, ackc_in;
   logic [i2cms_pkg::ByteWidth-1:0]   rxb_ff, rxb_in;
   logic                              fail_ff, fail_in;

   // Pin levels set on entering a phase.
   function automatic pins_type enter_pins(input phase_type p, input pins_type cur,
                                           input logic ack_c);
      pins_type n;
      n = cur;
      case (p)
         PH_ST1: begin n.oe = 1'b1; n.sda = 1'b1; n.scl = 1'b1; end
         PH_ST2: begin n.sda = 1'b0; n.scl = 1'b1; end
         PH_SP1: begin n.oe = 1'b1; n.scl = 1'b0; n.sda = 1'b0; end
         PH_SP2: begin n.scl = 1'b1; n.sda = 1'b1; end
         PH_SB_LO: begin
            n.oe    = 1'b1;
            n.scl   = 1'b0;
            n.sda   = cur.shift[i2cms_pkg::ByteWidth-1];
            n.shift = {cur.shift[i2cms_pkg::ByteWidth-2:0], 1'b0};
         end
         PH_SB_HI, PH_WA2, PH_RB_HI, PH_AK_HI: n.scl = 1'b1;
         PH_WA1: begin n.oe = 1'b0; n.sda = 1'b1; end
         PH_RB_LO: begin n.oe = 1'b0; n.sda = 1'b1; n.scl = 1'b0; end
         PH_AK_LO: begin n.scl = 1'b0; n.oe = 1'b1; n.sda = ~ack_c; end
         default: n = cur;
      endcase
      return n;
   endfunction

   function automatic logic [i2cms_pkg::TickWidth-1:0] at_least_one(
      input logic [i2cms_pkg::TickWidth-1:0] v);
      return (v == '0) ? i2cms_pkg::TickWidth'(1) : v;
   endfunction

   function automatic logic [i2cms_pkg::TickWidth-1:0] phase_len(
      input phase_type p, input i2cms_pkg::cfg_type c);
      logic [i2cms_pkg::TickWidth-1:0] len;
      case (p)
         PH_ST1, PH_ST2, PH_SP1, PH_SP2:
            len = at_least_one(c.start_hold);
         PH_SB_LO, PH_SB_HI, PH_RB_LO, PH_AK_LO, PH_AK_HI:
            len = at_least_one(c.bit_half);
         default:
            len = at_least_one(c.short_phase);
      endcase
      return len;
   endfunction

   logic                              go_a, go_b, done;
   phase_type                         pa, pb;
   logic [i2cms_pkg::TickWidth-1:0]   tick_inc;

   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      bitc_in  = bitc_ff;
      wait_in  = wait_ff;
      pins_in  = pins_ff;
      ackc_in  = ackc_ff;
      rxb_in   = rxb_ff;
      fail_in  = fail_ff;
      done     = 1'b0;
      go_a     = 1'b0;
      pa       = PH_IDLE;
      go_b     = 1'b0;
      pb       = PH_IDLE;
      tick_inc = '0;

      // Command launch from idle.
      if (phase_ff == PH_IDLE) begin
         case (req.opcode)
            i2cms_pkg::OP_START: begin go_a = 1'b1; pa = PH_ST1; end
            i2cms_pkg::OP_STOP:  begin go_a = 1'b1; pa = PH_SP1; end
            i2cms_pkg::OP_SEND: begin
               pins_in.shift = req.tx_byte;
               bitc_in       = '0;
               go_a          = 1'b1;
               pa            = PH_SB_LO;
            end
            i2cms_pkg::OP_WACK: begin
               fail_in = 1'b0;
               wait_in = '0;
               go_a    = 1'b1;
               pa      = PH_WA1;
            end
            i2cms_pkg::OP_READ: begin
               ackc_in       = req.ack_after_read;
               pins_in.shift = '0;
               bitc_in       = '0;
               go_a          = 1'b1;
               pa            = PH_RB_LO;
            end
            default: go_a = 1'b0;
         endcase
      end
      if (go_a) begin
         phase_in = pa;
         tick_in  = '0;
         pins_in  = enter_pins(pa, pins_in, ackc_in);
      end

      // Pin levels of this tick are those of the phase it belongs to.
      rsp.scl      = pins_in.scl;
      rsp.sda_out  = pins_in.sda;
      rsp.sda_oe   = pins_in.oe;
      rsp.busy_res = (phase_in != PH_IDLE);

      if (phase_in == PH_WA3) begin
         if (!req.sda_in) begin
            pins_in.scl = 1'b0;
            phase_in    = PH_IDLE;
            done        = 1'b1;
         end else if (wait_in >= cfg.ack_timeout) begin
            fail_in = 1'b1;
            go_b    = 1'b1;
            pb      = PH_SP1;
         end else begin
            wait_in = wait_in + 1'b1;
         end
      end else if (phase_in != PH_IDLE) begin
         if (phase_in == PH_RB_HI && tick_in == '0) begin
            pins_in.shift = {pins_in.shift[i2cms_pkg::ByteWidth-2:0], req.sda_in};
         end
         tick_inc = tick_in + 1'b1;
         tick_in  = tick_inc;
         if (tick_inc >= phase_len(phase_in, cfg)) begin
            case (phase_in)
               PH_ST1: begin go_b = 1'b1; pb = PH_ST2; end
               PH_ST2: begin pins_in.scl = 1'b0; phase_in = PH_IDLE; done = 1'b1; end
               PH_SP1: begin go_b = 1'b1; pb = PH_SP2; end
               PH_SP2: begin phase_in = PH_IDLE; done = 1'b1; end
               PH_SB_LO: begin go_b = 1'b1; pb = PH_SB_HI; end
               PH_SB_HI: begin
                  pins_in.scl = 1'b0;
                  bitc_in     = bitc_in + 1'b1;
                  if (bitc_in >= 4'd8) begin
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end else begin
                     go_b = 1'b1;
                     pb   = PH_SB_LO;
                  end
               end
               PH_WA1: begin go_b = 1'b1; pb = PH_WA2; end
               PH_WA2: begin go_b = 1'b1; pb = PH_WA3; end
               PH_RB_LO: begin go_b = 1'b1; pb = PH_RB_HI; end
               PH_RB_HI: begin
                  bitc_in = bitc_in + 1'b1;
                  go_b    = 1'b1;
                  if (bitc_in >= 4'd8) begin
                     rxb_in = pins_in.shift;
                     pb     = PH_AK_LO;
                  end else begin
                     pb = PH_RB_LO;
                  end
               end
               PH_AK_LO: begin go_b = 1'b1; pb = PH_AK_HI; end
               PH_AK_HI: begin pins_in.scl = 1'b0; phase_in = PH_IDLE; done = 1'b1; end
               default: phase_in = PH_IDLE;
            endcase
         end
      end
      if (go_b) begin
         phase_in = pb;
         tick_in  = '0;
         pins_in  = enter_pins(pb, pins_in, ackc_in);
      end

      rsp.done_res   = done;
      rsp.rx_byte    = rxb_in;
      rsp.ack_failed = fail_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         bitc_ff  <= '0;
         wait_ff  <= '0;
         pins_ff  <= '{scl: 1'b1, sda: 1'b1, oe: 1'b1, shift: '0};
         ackc_ff  <= 1'b0;
         rxb_ff   <= '0;
         fail_ff  <= 1'b0;
      end else if (tick_en) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bitc_ff  <= bitc_in;
         wait_ff  <= wait_in;
         pins_ff  <= pins_in;
         ackc_ff  <= ackc_in;
         rxb_ff   <= rxb_in;
         fail_ff  <= fail_in;
      end
   end

endmodule

>>> hw/rtl/i2cms_rsp_reg.sv
// Result register between the sequencer and the result stream.
`timescale 1ns / 1ps

module i2cms_rsp_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  i2cms_pkg::rsp_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output i2cms_pkg::rsp_type out_data
);

   logic               valid_ff;
   i2cms_pkg::rsp_type data_ff;

   // A new result may load while the held one is taken in the same cycle.
   assign in_ready  = ~valid_ff | out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

endmodule

>>> hw/rtl/i2c_master_bit_sequencer_unit.sv
// Top level of the I2C master bit sequencer.
`timescale 1ns / 1ps

// Each request transfer is one bus timing tick carrying the sampled SDA level and, while
// the sequencer is idle, a command: start, stop, send byte, wait for acknowledge or read
// byte. Every tick returns exactly one response with the SCL level, SDA drive value and
// direction, busy, a one-tick done pulse, the last received byte and the ack-failure flag.
// A tick's response is registered; a new one is taken every clock as long as the
// response register is empty or being drained. Phase lengths come from the timing
// registers on the csr port, which should be written only while no command is running.
module i2c_master_bit_sequencer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] opcode, [10:3] tx_byte, [11] ack_after_read, [12] sda_in, [15:13] zero
   input  logic [15:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] scl, [1] sda_out, [2] sda_oe, [3] busy_res, [4] done_res, [12:5] rx_byte,
   // [13] ack_failed, [15:14] zero
   output logic [15:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   i2cms_pkg::cfg_type cfg;
   i2cms_pkg::req_type req;
   i2cms_pkg::rsp_type core_rsp;
   i2cms_pkg::rsp_type out_rsp;
   logic               tick_en;

   assign req.opcode         = req_tdata[2:0];
   assign req.tx_byte        = req_tdata[10:3];
   assign req.ack_after_read = req_tdata[11];
   assign req.sda_in         = req_tdata[12];

   assign tick_en = req_tvalid & req_tready;

   i2cms_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   i2cms_core u_core (
      .clock   (clock),
      .reset   (reset),
      .tick_en (tick_en),
      .req     (req),
      .cfg     (cfg),
      .rsp     (core_rsp)
   );

   i2cms_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (core_rsp),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_rsp)
   );

   assign rsp_tdata = {2'b00, out_rsp.ack_failed, out_rsp.rx_byte, out_rsp.done_res,
                       out_rsp.busy_res, out_rsp.sda_oe, out_rsp.sda_out, out_rsp.scl};

endmodule
